// ===== sv/fcp_pkg.sv =====
`timescale 1ns / 1ps

package fcp_pkg;

  // Table geometry
  localparam int NumFlows = 1024;
  localparam int AddrW    = $clog2(NumFlows);
  localparam int IndexW   = 10;

  // Time base
  localparam int TimeW     = 32;
  localparam int MsPerTick = 4;

  // Token scaling: rate in bit/s to bytes per millisecond
  localparam int BitsPerByte = 8;
  localparam int MsecPerSec  = 1000;
  localparam int ByteMsDiv   = BitsPerByte * MsecPerSec;
  localparam int DivPreShift = 6;                         // 8000 = 64 * 125
  localparam int DivOdd      = ByteMsDiv >> DivPreShift;
  localparam int DivInW      = 32 - DivPreShift;
  localparam int DivOddW     = $clog2(DivOdd);
  localparam int RecipShift  = DivInW + DivOddW;
  localparam int RecipW      = RecipShift - DivOddW + 1;
  // ceil(2^RecipShift / DivOdd); exact quotient for any DivInW-bit dividend
  localparam logic [RecipW-1:0] RecipMul =
      RecipW'(((64'd1 << RecipShift) / DivOdd) + 64'd1);
  localparam int RateDivW = $clog2((64'd1 << 32) / ByteMsDiv + 1);
  localparam int ProdW    = DivInW + RecipW;

  typedef enum logic [1:0] {
    MODE_PACKET = 2'd0,
    MODE_SET    = 2'd1,
    MODE_REMOVE = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_SUB,
    ST_CMP,
    ST_WB
  } state_e;

  typedef struct packed {
    logic                active;
    logic [RateDivW-1:0] rate_div;
    logic [31:0]         cbs;
    logic [31:0]         ebs;
    logic [31:0]         committed;
    logic [31:0]         excess;
    logic [TimeW-1:0]    last_refill;
    logic [31:0]         green_pkts;
    logic [31:0]         red_pkts;
    logic [63:0]         green_octs;
    logic [63:0]         red_octs;
  } flow_entry_t;

  localparam int EntryW = $bits(flow_entry_t);

endpackage

// ===== sv/fcp_ram.sv =====
`timescale 1ns / 1ps

module fcp_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/per_flow_car_policer_top.sv =====
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// command   start_i in, busy_o out    mode_i, flow_index_i, packet_length_i, now_ticks_i,
//                                     rate_bits_per_sec_i, committed_burst_i, excess_burst_i
// result    done_o out (one cycle)    drop_o, flow_active_o, committed_count_o,
//                                     excess_count_o, green/red_packets_o, green/red_bytes_o
//
// One transaction at a time: taken when start_i is high and busy_o low, its
// result strobes on done_o in the cycle in which busy_o falls again. It walks
// the flow memory through READ, MUL, SUB, CMP and WB (read and multiply,
// refill subtract, burst compare, a spare slot, write back), all on one
// single-port RAM. After reset the block sweeps all NumFlows (1024) entries
// of the flow memory clear, one entry a cycle, with busy_o high.
// The receiver cannot stall: each result is shown for exactly one cycle.

module per_flow_car_policer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  mode_i,
  input  logic [9:0]  flow_index_i,
  input  logic [15:0] packet_length_i,
  input  logic [31:0] now_ticks_i,
  input  logic [31:0] rate_bits_per_sec_i,
  input  logic [31:0] committed_burst_i,
  input  logic [31:0] excess_burst_i,
  output logic        done_o,
  output logic        drop_o,
  output logic        flow_active_o,
  output logic [31:0] committed_count_o,
  output logic [31:0] excess_count_o,
  output logic [31:0] green_packets_o,
  output logic [31:0] red_packets_o,
  output logic [63:0] green_bytes_o,
  output logic [63:0] red_bytes_o
);

  // ---------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------
  fcp_pkg::state_e state_q, state_d;
  logic [fcp_pkg::AddrW:0] clr_cnt_q, clr_cnt_d;

  // Captured transaction
  fcp_pkg::mode_e             mode_q;
  logic [fcp_pkg::IndexW-1:0] idx_q;
  logic [15:0]                len_q;
  logic [fcp_pkg::TimeW-1:0]  now_q;
  logic [31:0]                rate_q;
  logic [31:0]                cbs_in_q;
  logic [31:0]                ebs_in_q;

  // Datapath registers
  fcp_pkg::flow_entry_t            entry_q;
  logic [31:0]                     tc0_q;    // count plus packet length
  logic [31:0]                     tok_q;    // tokens earned since last refill
  logic                            refill_q; // any time elapsed
  logic [fcp_pkg::RateDivW-1:0]    div_q;    // rate in bytes per ms, for set
  logic [31:0]                     tc1_q;    // count after refill
  logic                            over_q;   // committed burst exceeded
  logic [31:0]                     diff_q;   // overflow beyond committed burst

  // Result registers
  logic        done_q;
  logic        drop_q;
  logic        act_q;
  logic [31:0] cc_q, ec_q, gp_q, rp_q;
  logic [63:0] gb_q, rb_q;

  // RAM port
  logic                      ram_we, ram_re;
  logic [fcp_pkg::AddrW-1:0] ram_addr;
  fcp_pkg::flow_entry_t      ram_wdata, ram_rdata;

  logic accept;
  assign accept = start_i && (state_q == fcp_pkg::ST_IDLE);
  assign busy_o = (state_q != fcp_pkg::ST_IDLE);

  fcp_ram #(
    .Width(fcp_pkg::EntryW),
    .Depth(fcp_pkg::NumFlows)
  ) u_flow_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // ---------------------------------------------------------------------
  // Stage arithmetic
  // ---------------------------------------------------------------------
  logic [fcp_pkg::TimeW-1:0]   delta;
  logic [31:0]                 ms32;
  logic [31:0]                 tok_full;
  logic [fcp_pkg::ProdW-1:0]   recip_prod;
  logic [31:0]                 tok_use;
  logic [31:0]                 te;
  logic                        in_range;

  always_comb begin
    delta      = now_q - ram_rdata.last_refill;
    ms32       = 32'(delta * fcp_pkg::TimeW'(fcp_pkg::MsPerTick));
    tok_full   = 32'(ms32 * ram_rdata.rate_div);
    recip_prod = fcp_pkg::ProdW'(rate_q[31:fcp_pkg::DivPreShift]) *
                 fcp_pkg::ProdW'(fcp_pkg::RecipMul);
    tok_use    = (tok_q < tc0_q) ? tok_q : tc0_q;
    te         = entry_q.excess + diff_q;
    in_range   = 32'(idx_q) < 32'(fcp_pkg::NumFlows);
  end

  // ---------------------------------------------------------------------
  // Next state, RAM control and write-back word
  // ---------------------------------------------------------------------
  logic                 wb_drop;
  logic                 wb_act;
  fcp_pkg::flow_entry_t wb_entry;

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = fcp_pkg::AddrW'(idx_q);
    wb_drop   = 1'b0;
    wb_act    = entry_q.active;
    wb_entry  = entry_q;

    // Outcome of the item, used in write-back
    unique case (mode_q)
      fcp_pkg::MODE_SET: begin
        if (!entry_q.active) begin
          wb_entry.green_pkts = '0;
          wb_entry.red_pkts   = '0;
          wb_entry.green_octs = '0;
          wb_entry.red_octs   = '0;
        end
        wb_entry.rate_div    = div_q;
        wb_entry.cbs         = cbs_in_q;
        wb_entry.ebs         = ebs_in_q;
        wb_entry.committed   = '0;
        wb_entry.excess      = '0;
        wb_entry.last_refill = '0;
        wb_entry.active      = 1'b1;
        wb_act               = 1'b1;
      end
      fcp_pkg::MODE_REMOVE: begin
        wb_entry.active = 1'b0;
        wb_act          = 1'b0;
      end
      fcp_pkg::MODE_PACKET: begin
        if (entry_q.active) begin
          wb_entry.committed = tc1_q;
          // last_refill equals now whenever no time has elapsed
          wb_entry.last_refill = now_q;
          if (over_q) begin
            if (te > entry_q.ebs) begin
              wb_drop         = 1'b1;
              wb_entry.excess = '0;
            end else begin
              wb_entry.excess = te;
            end
          end
          if (wb_drop) begin
            wb_entry.red_octs  = entry_q.red_octs + 64'(len_q);
            wb_entry.red_pkts  = entry_q.red_pkts + 32'd1;
            wb_entry.committed = tc1_q - 32'(len_q);
          end else begin
            wb_entry.green_octs = entry_q.green_octs + 64'(len_q);
            wb_entry.green_pkts = entry_q.green_pkts + 32'd1;
          end
        end
      end
      default: begin
        // unused selector: entry untouched
      end
    endcase

    ram_wdata = wb_entry;

    unique case (state_q)
      fcp_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_cnt_q[fcp_pkg::AddrW-1:0];
        ram_wdata = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == (fcp_pkg::AddrW + 1)'(fcp_pkg::NumFlows - 1)) begin
          state_d = fcp_pkg::ST_IDLE;
        end
      end
      fcp_pkg::ST_IDLE: begin
        ram_addr = fcp_pkg::AddrW'(flow_index_i);
        if (start_i) begin
          ram_re  = 1'b1;
          state_d = fcp_pkg::ST_READ;
        end
      end
      fcp_pkg::ST_READ: state_d = fcp_pkg::ST_MUL;
      fcp_pkg::ST_MUL:  state_d = fcp_pkg::ST_SUB;
      fcp_pkg::ST_SUB:  state_d = fcp_pkg::ST_CMP;
      fcp_pkg::ST_CMP:  state_d = fcp_pkg::ST_WB;
      fcp_pkg::ST_WB: begin
        ram_we  = in_range && (mode_q == fcp_pkg::MODE_SET ||
                               mode_q == fcp_pkg::MODE_REMOVE ||
                               (mode_q == fcp_pkg::MODE_PACKET && entry_q.active));
        state_d = fcp_pkg::ST_IDLE;
      end
      default: state_d = fcp_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= fcp_pkg::ST_CLEAR;
      clr_cnt_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      done_q    <= (state_q == fcp_pkg::ST_WB);
    end
  end

  // ---------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q   <= fcp_pkg::mode_e'(mode_i);
      idx_q    <= flow_index_i;
      len_q    <= packet_length_i;
      now_q    <= fcp_pkg::TimeW'(now_ticks_i);
      rate_q   <= rate_bits_per_sec_i;
      cbs_in_q <= committed_burst_i;
      ebs_in_q <= excess_burst_i;
    end

    // read data valid: charge length, earn tokens, scale rate for set
    if (state_q == fcp_pkg::ST_READ) begin
      entry_q  <= ram_rdata;
      tc0_q    <= ram_rdata.committed + 32'(len_q);
      tok_q    <= tok_full;
      refill_q <= (delta != '0);
      div_q    <= recip_prod[fcp_pkg::RecipShift +: fcp_pkg::RateDivW];
    end

    if (state_q == fcp_pkg::ST_MUL) begin
      tc1_q <= refill_q ? (tc0_q - tok_use) : tc0_q;
    end

    if (state_q == fcp_pkg::ST_SUB) begin
      over_q <= tc1_q > entry_q.cbs;
      diff_q <= tc1_q - entry_q.cbs;
    end

    if (state_q == fcp_pkg::ST_CMP) begin
      // empty pipeline slot; the committed compare is already registered
    end

    if (state_q == fcp_pkg::ST_WB) begin
      if (in_range && wb_act) begin
        drop_q <= wb_drop;
        act_q  <= 1'b1;
        cc_q   <= wb_entry.committed;
        ec_q   <= wb_entry.excess;
        gp_q   <= wb_entry.green_pkts;
        rp_q   <= wb_entry.red_pkts;
        gb_q   <= wb_entry.green_octs;
        rb_q   <= wb_entry.red_octs;
      end else begin
        drop_q <= 1'b0;
        act_q  <= 1'b0;
        cc_q   <= '0;
        ec_q   <= '0;
        gp_q   <= '0;
        rp_q   <= '0;
        gb_q   <= '0;
        rb_q   <= '0;
      end
    end
  end

  assign done_o            = done_q;
  assign drop_o            = drop_q;
  assign flow_active_o     = act_q;
  assign committed_count_o = cc_q;
  assign excess_count_o    = ec_q;
  assign green_packets_o   = gp_q;
  assign red_packets_o     = rp_q;
  assign green_bytes_o     = gb_q;
  assign red_bytes_o       = rb_q;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

// Testbench for the per-flow policer table. A directed table comes first, then
// random traffic on a few flows that are kept busy. A local copy of the flow
// table predicts every result not typed in by hand. One transaction is in flight
// at a time, and every done_o strobe is checked against the oldest expectation.

module tb;

  // Mode value that the block decodes as "no operation"
  localparam logic [1:0] ModeUnused = 2'd3;

  localparam int RandomItems = 1275;
  localparam int HotFlows    = 16;
  localparam int CycleLimit  = 200000;   // clear sweep plus ~1.3k items, many times over
  localparam int DrainCycles = 20;

  typedef struct packed {
    logic [1:0]  mode;
    logic [9:0]  flow;
    logic [15:0] len;
    logic [31:0] now;
    logic [31:0] rate;
    logic [31:0] cbs;
    logic [31:0] ebs;
  } policer_cmd_t;

  typedef struct packed {
    logic        drop;
    logic        active;
    logic [31:0] committed;
    logic [31:0] excess;
    logic [31:0] green_pkts;
    logic [31:0] red_pkts;
    logic [63:0] green_octs;
    logic [63:0] red_octs;
  } policer_result_t;

  typedef struct packed {
    policer_cmd_t    cmd;
    logic            typed_in;   // expectation written out by hand
    policer_result_t result;
  } directed_row_t;

  localparam policer_result_t InactiveResult = '0;
  localparam policer_result_t FreshResult    =
      '{1'b0, 1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 64'd0, 64'd0};

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  mode_i;
  logic [9:0]  flow_index_i;
  logic [15:0] packet_length_i;
  logic [31:0] now_ticks_i;
  logic [31:0] rate_bits_per_sec_i;
  logic [31:0] committed_burst_i;
  logic [31:0] excess_burst_i;
  logic        done_o;
  logic        drop_o;
  logic        flow_active_o;
  logic [31:0] committed_count_o;
  logic [31:0] excess_count_o;
  logic [31:0] green_packets_o;
  logic [31:0] red_packets_o;
  logic [63:0] green_bytes_o;
  logic [63:0] red_bytes_o;

  per_flow_car_policer_top i_dut (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .mode_i,
    .flow_index_i,
    .packet_length_i,
    .now_ticks_i,
    .rate_bits_per_sec_i,
    .committed_burst_i,
    .excess_burst_i,
    .done_o,
    .drop_o,
    .flow_active_o,
    .committed_count_o,
    .excess_count_o,
    .green_packets_o,
    .red_packets_o,
    .green_bytes_o,
    .red_bytes_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow flow table. Entries other than the active flag are only ever read
  // once a set transaction has written them.
  // ---------------------------------------------------------------------------
  bit          flow_on      [fcp_pkg::NumFlows];
  bit [31:0]   flow_cir     [fcp_pkg::NumFlows];
  bit [31:0]   flow_cbs     [fcp_pkg::NumFlows];
  bit [31:0]   flow_ebs     [fcp_pkg::NumFlows];
  bit [31:0]   bucket_c     [fcp_pkg::NumFlows];
  bit [31:0]   bucket_e     [fcp_pkg::NumFlows];
  bit [31:0]   refill_stamp [fcp_pkg::NumFlows];
  bit [31:0]   green_pkts   [fcp_pkg::NumFlows];
  bit [31:0]   red_pkts     [fcp_pkg::NumFlows];
  bit [63:0]   green_octets [fcp_pkg::NumFlows];
  bit [63:0]   red_octets   [fcp_pkg::NumFlows];

  policer_result_t awaited_results[$];
  directed_row_t   directed_rows[$];

  int  mismatch_count;
  int  stray_count;
  int  results_seen;
  int  packets_sent, sets_sent, removes_sent, others_sent, drops_predicted;
  int  cycle_count;
  bit  idling_allowed;

  // Apply one transaction to the shadow table and return what the block
  // should report for it.
  function automatic policer_result_t police_item(input policer_cmd_t cmd);
    policer_result_t res;
    int unsigned     f;
    bit [31:0]       tc, te, tok, delta;
    bit [63:0]       ms;
    bit              dropped;
    res     = InactiveResult;
    f       = cmd.flow;
    dropped = 1'b0;
    if (cmd.mode == fcp_pkg::MODE_SET) begin
      if (!flow_on[f]) begin
        green_pkts[f]   = '0;
        red_pkts[f]     = '0;
        green_octets[f] = '0;
        red_octets[f]   = '0;
      end
      flow_cir[f]     = cmd.rate;
      flow_cbs[f]     = cmd.cbs;
      flow_ebs[f]     = cmd.ebs;
      bucket_c[f]     = '0;
      bucket_e[f]     = '0;
      refill_stamp[f] = '0;
      flow_on[f]      = 1'b1;
    end else if (cmd.mode == fcp_pkg::MODE_REMOVE) begin
      flow_on[f] = 1'b0;
    end else if (cmd.mode == fcp_pkg::MODE_PACKET && flow_on[f]) begin
      tc    = bucket_c[f] + 32'(cmd.len);
      delta = cmd.now - refill_stamp[f];
      ms    = 64'(delta) * 64'(fcp_pkg::MsPerTick);
      if (ms != 64'd0) begin
        // token product truncated to 32 bits on purpose
        tok             = 32'(ms * 64'(flow_cir[f] / 32'(fcp_pkg::ByteMsDiv)));
        tc              = tc - ((tok < tc) ? tok : tc);
        refill_stamp[f] = cmd.now;
      end
      if (tc > flow_cbs[f]) begin
        te = bucket_e[f] + (tc - flow_cbs[f]);
        if (te > flow_ebs[f]) begin
          te      = '0;
          dropped = 1'b1;
        end
        bucket_e[f] = te;
      end
      if (dropped) begin
        red_octets[f] = red_octets[f] + 64'(cmd.len);
        red_pkts[f]   = red_pkts[f] + 32'd1;
        tc            = tc - 32'(cmd.len);   // may wrap below zero
      end else begin
        green_octets[f] = green_octets[f] + 64'(cmd.len);
        green_pkts[f]   = green_pkts[f] + 32'd1;
      end
      bucket_c[f] = tc;
    end
    if (flow_on[f]) begin
      res.drop       = dropped;
      res.active     = 1'b1;
      res.committed  = bucket_c[f];
      res.excess     = bucket_e[f];
      res.green_pkts = green_pkts[f];
      res.red_pkts   = red_pkts[f];
      res.green_octs = green_octets[f];
      res.red_octs   = red_octets[f];
    end
    return res;
  endfunction

  function automatic void add_row(input logic [1:0] mode, input logic [9:0] flow,
                                  input logic [15:0] len, input logic [31:0] now,
                                  input logic [31:0] rate, input logic [31:0] cbs,
                                  input logic [31:0] ebs, input bit typed_in,
                                  input policer_result_t result);
    directed_row_t row;
    row.cmd      = '{mode, flow, len, now, rate, cbs, ebs};
    row.typed_in = typed_in;
    row.result   = result;
    directed_rows.push_back(row);
  endfunction

  // Drive one command at the falling edge and offer it until taken, idling
  // now and then, then log the expectation at the accepting edge. Returns
  // positioned on a falling edge.
  task automatic issue_cmd(input policer_cmd_t cmd, input bit typed_in,
                           input policer_result_t typed_result);
    policer_result_t predicted;
    bit              taken;
    taken               = 1'b0;
    mode_i              <= cmd.mode;
    flow_index_i        <= cmd.flow;
    packet_length_i     <= cmd.len;
    now_ticks_i         <= cmd.now;
    rate_bits_per_sec_i <= cmd.rate;
    committed_burst_i   <= cmd.cbs;
    excess_burst_i      <= cmd.ebs;
    while (!taken) begin
      if (idling_allowed && $urandom_range(0, 99) < 21) start_i <= 1'b0;
      else start_i <= 1'b1;
      @(posedge clk_i);
      taken = (start_i === 1'b1) && (busy_o === 1'b0);
      if (!taken) @(negedge clk_i);
    end
    predicted = police_item(cmd);
    awaited_results.push_back(typed_in ? typed_result : predicted);
    if (cmd.mode == fcp_pkg::MODE_PACKET) packets_sent++;
    else if (cmd.mode == fcp_pkg::MODE_SET) sets_sent++;
    else if (cmd.mode == fcp_pkg::MODE_REMOVE) removes_sent++;
    else others_sent++;
    if (predicted.drop) drops_predicted++;
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: each strobe is compared field by field with the oldest
  // expectation.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, name,
                 exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    policer_result_t exp_r;
    if (rst_ni === 1'b1 && done_o !== 1'b0) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        stray_count++;
        if (stray_count <= 10) $display("%0t: result with nothing outstanding", $realtime);
      end else begin
        exp_r = awaited_results.pop_front();
        check_field("drop", 64'(exp_r.drop), 64'(drop_o));
        check_field("flow_active", 64'(exp_r.active), 64'(flow_active_o));
        check_field("committed_count", 64'(exp_r.committed), 64'(committed_count_o));
        check_field("excess_count", 64'(exp_r.excess), 64'(excess_count_o));
        check_field("green_packets", 64'(exp_r.green_pkts), 64'(green_packets_o));
        check_field("red_packets", 64'(exp_r.red_pkts), 64'(red_packets_o));
        check_field("green_bytes_o", exp_r.green_octs, green_bytes_o);
        check_field("red_bytes_o", exp_r.red_octs, red_bytes_o);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               awaited_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    policer_cmd_t cmd;
    logic [9:0]   hot[HotFlows];
    logic [31:0]  clock_ticks;
    int           pick;

    rst_ni              = 1'b0;
    start_i             = 1'b0;
    mode_i              = fcp_pkg::MODE_PACKET;
    flow_index_i        = '0;
    packet_length_i     = '0;
    now_ticks_i         = '0;
    rate_bits_per_sec_i = '0;
    committed_burst_i   = '0;
    excess_burst_i      = '0;
    idling_allowed      = 1'b1;

    // Directed table. Rows with a typed-in result are the obvious ones; the
    // rest go through the predictor.
    // Untouched table: everything reads as inactive.
    add_row(fcp_pkg::MODE_PACKET, 10'd0, 16'hFFFF, 32'hFFFF_FFFF, '0, '0, '0, 1,
            InactiveResult);
    add_row(fcp_pkg::MODE_REMOVE, 10'd1023, '0, '0, '0, '0, '0, 1, InactiveResult);
    add_row(ModeUnused, 10'd0, '0, '0, '0, '0, '0, 1, InactiveResult);
    // Flow 0 at the top of every range
    add_row(fcp_pkg::MODE_SET, 10'd0, '0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            1, FreshResult);
    add_row(fcp_pkg::MODE_PACKET, 10'd0, 16'hFFFF, 32'd0, '0, '0, '0, 1,
            '{1'b0, 1'b1, 32'd65535, 32'd0, 32'd1, 32'd0, 64'd65535, 64'd0});
    add_row(fcp_pkg::MODE_PACKET, 10'd0, 16'd0, 32'd1, '0, '0, '0, 0, '0);
    // Time wrap, and a token product that overflows 32 bits
    add_row(fcp_pkg::MODE_PACKET, 10'd0, 16'd1500, 32'hFFFF_FFFF, '0, '0, '0, 0, '0);
    add_row(fcp_pkg::MODE_PACKET, 10'd0, 16'd1500, 32'd0, '0, '0, '0, 0, '0);
    add_row(ModeUnused, 10'd0, '0, '0, '0, '0, '0, 0, '0);
    // Zero rate and zero bursts: any byte is red
    add_row(fcp_pkg::MODE_SET, 10'd1, '0, '0, 32'd0, 32'd0, 32'd0, 1, FreshResult);
    add_row(fcp_pkg::MODE_PACKET, 10'd1, 16'd1, 32'd0, '0, '0, '0, 1,
            '{1'b1, 1'b1, 32'd0, 32'd0, 32'd0, 32'd1, 64'd0, 64'd1});
    add_row(fcp_pkg::MODE_PACKET, 10'd1, 16'd0, 32'd5, '0, '0, '0, 0, '0);
    // Committed burst filling into excess, then a drop
    add_row(fcp_pkg::MODE_SET, 10'd2, '0, '0, 32'd80000, 32'd100, 32'd50, 1, FreshResult);
    add_row(fcp_pkg::MODE_PACKET, 10'd2, 16'd50, 32'd0, '0, '0, '0, 0, '0);
    add_row(fcp_pkg::MODE_PACKET, 10'd2, 16'd100, 32'd0, '0, '0, '0, 0, '0);
    add_row(fcp_pkg::MODE_PACKET, 10'd2, 16'd1, 32'd0, '0, '0, '0, 0, '0);
    // Update while active keeps the statistics
    add_row(fcp_pkg::MODE_SET, 10'd2, '0, '0, 32'd8000, 32'd10, 32'd10, 0, '0);
    add_row(fcp_pkg::MODE_REMOVE, 10'd2, '0, '0, '0, '0, '0, 1, InactiveResult);
    // Re-adding after removal starts from clean statistics
    add_row(fcp_pkg::MODE_SET, 10'd2, '0, '0, 32'd8000, 32'd10, 32'd10, 1, FreshResult);
    // Drop after a refill leaves less than the packet: committed count wraps
    add_row(fcp_pkg::MODE_SET, 10'd3, '0, '0, 32'd240000, 32'd10, 32'd50, 1, FreshResult);
    add_row(fcp_pkg::MODE_PACKET, 10'd3, 16'd50, 32'd0, '0, '0, '0, 0, '0);
    add_row(fcp_pkg::MODE_PACKET, 10'd3, 16'd100, 32'd1, '0, '0, '0, 0, '0);
    add_row(fcp_pkg::MODE_PACKET, 10'd3, 16'hFFFF, 32'd1, '0, '0, '0, 0, '0);
    // Top entry of the table
    add_row(fcp_pkg::MODE_SET, 10'd1023, '0, '0, 32'h8000_0000, 32'd1000, 32'd1000, 1,
            FreshResult);
    add_row(fcp_pkg::MODE_PACKET, 10'd1023, 16'h8000, 32'h8000_0000, '0, '0, '0, 0, '0);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Block sweeps its memory after reset with busy_o high; the handshake
    // simply waits that out.
    foreach (directed_rows[i])
      issue_cmd(directed_rows[i].cmd, directed_rows[i].typed_in, directed_rows[i].result);

    // Random part: a handful of hot flows carry well-formed traffic so the
    // buckets fill, spill and drain; the rest is removal, no-ops and noise.
    hot[0] = 10'd0;
    hot[1] = 10'd1023;
    for (int i = 2; i < HotFlows; i++)
      hot[i] = 10'($urandom_range(0, fcp_pkg::NumFlows - 1));
    clock_ticks = $urandom;

    for (int n = 0; n < RandomItems; n++) begin
      idling_allowed = !(n >= 400 && n < 650);
      cmd  = policer_cmd_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom});
      pick = $urandom_range(0, 99);
      if (n < HotFlows) begin
        cmd.mode = fcp_pkg::MODE_SET;
        cmd.flow = hot[n];
        cmd.rate = $urandom_range(0, 400) * 8000 + $urandom_range(0, 7999);
        cmd.cbs  = $urandom_range(0, 3000);
        cmd.ebs  = $urandom_range(0, 3000);
      end else if (pick < 70) begin
        cmd.mode = fcp_pkg::MODE_PACKET;
        cmd.flow = hot[$urandom_range(0, HotFlows - 1)];
        if ($urandom_range(0, 9) != 0) cmd.len = 16'($urandom_range(40, 1500));
        if ($urandom_range(0, 49) == 0) clock_ticks = $urandom;
        else clock_ticks = clock_ticks + $urandom_range(0, 2);
        cmd.now = clock_ticks;
      end else if (pick < 80) begin
        cmd.mode = fcp_pkg::MODE_SET;
        cmd.flow = hot[$urandom_range(0, HotFlows - 1)];
        if ($urandom_range(0, 7) != 0) begin
          cmd.rate = $urandom_range(0, 400) * 8000 + $urandom_range(0, 7999);
          cmd.cbs  = $urandom_range(0, 3000);
          cmd.ebs  = $urandom_range(0, 3000);
        end
      end else if (pick < 85) begin
        cmd.mode = fcp_pkg::MODE_REMOVE;
        cmd.flow = hot[$urandom_range(0, HotFlows - 1)];
      end else if (pick < 90) begin
        cmd.mode = ModeUnused;
      end
      // otherwise: fully random transaction
      issue_cmd(cmd, 1'b0, '0);
    end
    start_i <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d packets (%0d predicted drops), %0d sets, %0d removes, %0d no-ops",
             packets_sent, drops_predicted, sets_sent, removes_sent, others_sent);
    $display("%0d results checked, %0d field mismatches, %0d unexpected results",
             results_seen, mismatch_count, stray_count);
    if (mismatch_count == 0 && stray_count == 0 && awaited_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== files.f =====
sv/fcp_pkg.sv
sv/fcp_ram.sv
sv/per_flow_car_policer_top.sv
dv/tb.sv
